FILE: hdl/csvg_pkg.sv
// Shared constants and sizing helpers for the cube sphere vertex generator.
// No dependencies; every other file of the block refers to this package.
package csvg_pkg;

    // Fixed field widths
    localparam int IDX_W  = 15;
    localparam int POS_W  = 17;
    localparam int RES_W  = 7;
    localparam int RAD_W  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Default largest grid resolution
    localparam int MAX_RES_DEF = 64;

    // One scaled-coordinate bit is settled per search stage
    localparam int NSTEP = RAD_W;

    // Register reset values
    localparam logic [RES_W-1:0] RES_RST = 7'd2;
    localparam logic [RAD_W-1:0] RAD_RST = 16'd4096;

    // Register indexes (paddr word select)
    localparam logic REG_RESOLUTION = 1'b0;
    localparam logic REG_RADIUS     = 1'b1;

    // Bits needed to hold a resolution value up to max_res
    function automatic int res_w(input int max_res);
        return $clog2(max_res + 1);
    endfunction

    // Register stages of the index decode front end
    function automatic int dec_stages(input int max_res);
        return ($clog2(max_res) + 1) / 2 + 5;
    endfunction

endpackage

FILE: hdl/cube_sphere_vertex_generator_unit.sv
// Top level of the cube sphere vertex generator: APB registers, stage valids.
// Depends on csvg_pkg, csvg_decode and csvg_scale.
//
// Usage: write the grid resolution (0x0) and sphere_radius (0x4) over APB while
// the pipeline is empty, then stream vertex indices on vertex_valid/ready.
// Each transfer returns one result on pos_valid/ready: pos_x, pos_y, pos_z in
// Q4.12 and index_valid; an index past the vertex count returns zeros with
// index_valid low.
// Throughput is one vertex per cycle while the receiver takes results. Each
// input transfer passes through the decode stages, the scaler stages and the
// output register to pos_valid: the index decode dividers take two quotient
// bits a stage, and the scaling search takes one result bit a stage.
// Reset clears the stage valid bits and loads resolution 2 and radius 1.0.
// When the receiver stalls, stages behind a bubble keep moving, so new
// vertices are taken until every stage holds one; nothing is dropped.
module cube_sphere_vertex_generator_unit #(
    parameter int MAX_RESOLUTION = csvg_pkg::MAX_RES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [csvg_pkg::ADDR_W-1:0]            paddr,
    input  logic [csvg_pkg::DATA_W-1:0]            pwdata,
    output logic [csvg_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready,
    input  logic                                   vertex_valid,
    output logic                                   vertex_ready,
    input  logic [csvg_pkg::IDX_W-1:0]             vertex_index,
    output logic                                   pos_valid,
    input  logic                                   pos_ready,
    output logic signed [csvg_pkg::POS_W-1:0]      pos_x,
    output logic signed [csvg_pkg::POS_W-1:0]      pos_y,
    output logic signed [csvg_pkg::POS_W-1:0]      pos_z,
    output logic                                   index_valid
);

    localparam int RW     = csvg_pkg::res_w(MAX_RESOLUTION);
    localparam int DEC_ST = csvg_pkg::dec_stages(MAX_RESOLUTION);
    localparam int NSTEP  = csvg_pkg::NSTEP;
    localparam int NS     = DEC_ST + NSTEP + 1;
    localparam int SW     = 2 * RW + 2;
    localparam int HW     = 2 * RW + 34;
    localparam int PW     = csvg_pkg::POS_W;

    logic [csvg_pkg::RES_W-1:0] res_reg;
    logic [csvg_pkg::RAD_W-1:0] rad_reg;
    logic                       wr_en;

    logic [NS-1:0]         v_reg;
    logic [NS-1:0]         en;

    logic [SW-1:0]         s_d;
    logic [HW-1:0]         rhs_d [3];
    logic [2:0]            neg_d;
    logic                  iv_d;
    logic [csvg_pkg::RAD_W-1:0] q_s [3];
    logic [2:0]            neg_s;
    logic                  ivs_reg [0:NSTEP-1];

    logic signed [PW-1:0]  pos_next [3];
    logic signed [PW-1:0]  pos_reg  [3];
    logic                  iv_out_reg;

    // Register file
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= csvg_pkg::RES_RST;
            rad_reg <= csvg_pkg::RAD_RST;
        end
        else if (wr_en)
        begin
            case (paddr[csvg_pkg::ADDR_W-1])
                csvg_pkg::REG_RESOLUTION: res_reg <= pwdata[csvg_pkg::RES_W-1:0];
                csvg_pkg::REG_RADIUS:     rad_reg <= pwdata[csvg_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[csvg_pkg::ADDR_W-1])
            csvg_pkg::REG_RESOLUTION: prdata = csvg_pkg::DATA_W'(res_reg);
            csvg_pkg::REG_RADIUS:     prdata = csvg_pkg::DATA_W'(rad_reg);
            default:                  prdata = '0;
        endcase
    end

    // Stage advance: a stage moves when it is empty or the next one moves
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || pos_ready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= vertex_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign vertex_ready = en[0];
    assign pos_valid    = v_reg[NS-1];

    // Index decode and squared terms
    csvg_decode #(
        .MAX_RES (MAX_RESOLUTION)
    ) u_decode (
        .clk            (clk),
        .en             (en[DEC_ST-1:0]),
        .vertex_index   (vertex_index),
        .cfg_resolution (res_reg),
        .cfg_radius     (rad_reg),
        .s_out          (s_d),
        .rhs_out        (rhs_d),
        .neg_out        (neg_d),
        .iv_out         (iv_d)
    );

    // Per-axis normalize and scale
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        csvg_scale #(
            .MAX_RES (MAX_RESOLUTION)
        ) u_scale (
            .clk     (clk),
            .en      (en[DEC_ST+NSTEP-1:DEC_ST]),
            .s_in    (s_d),
            .rhs_in  (rhs_d[a]),
            .neg_in  (neg_d[a]),
            .q_out   (q_s[a]),
            .neg_out (neg_s[a])
        );
    end

    // Index-valid flag alongside the scaler stages
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTEP; k++)
        begin
            if (en[DEC_ST+k])
                ivs_reg[k] <= (k == 0) ? iv_d : ivs_reg[k-1];
        end
    end

    // Sign restore and out-of-range zeroing
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (!ivs_reg[NSTEP-1])
                pos_next[a] = '0;
            else if (neg_s[a])
                pos_next[a] = -$signed(PW'(q_s[a]));
            else
                pos_next[a] = $signed(PW'(q_s[a]));
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            pos_reg    <= pos_next;
            iv_out_reg <= ivs_reg[NSTEP-1];
        end
    end

    assign pos_x       = pos_reg[0];
    assign pos_y       = pos_reg[1];
    assign pos_z       = pos_reg[2];
    assign index_valid = iv_out_reg;

endmodule

FILE: hdl/csvg_decode.sv
// Front end: maps a vertex index to grid offsets, then forms |D|^2 and 4*R^2*d^2.
// Depends on csvg_pkg. Pipelined restoring dividers, two quotient bits a stage.
module csvg_decode #(
    parameter int MAX_RES = csvg_pkg::MAX_RES_DEF
) (
    input  logic                                      clk,
    input  logic [csvg_pkg::dec_stages(MAX_RES)-1:0]  en,
    input  logic [csvg_pkg::IDX_W-1:0]                vertex_index,
    input  logic [csvg_pkg::RES_W-1:0]                cfg_resolution,
    input  logic [csvg_pkg::RAD_W-1:0]                cfg_radius,
    output logic [2*csvg_pkg::res_w(MAX_RES)+1:0]     s_out,
    output logic [2*csvg_pkg::res_w(MAX_RES)+33:0]    rhs_out [3],
    output logic [2:0]                                neg_out,
    output logic                                      iv_out
);

    localparam int RW     = csvg_pkg::res_w(MAX_RES);
    localparam int QW     = $clog2(MAX_RES);
    localparam int DIV_ST = (QW + 1) / 2;
    localparam int CW     = 2 * RW + 3;
    localparam int VW     = (CW > csvg_pkg::IDX_W) ? CW : csvg_pkg::IDX_W;
    localparam int DW     = RW + 2;
    localparam int SW     = 2 * RW + 2;
    localparam int HW     = 2 * RW + 34;
    localparam int DEC_ST = csvg_pkg::dec_stages(MAX_RES);

    // Side face segment codes
    localparam logic [1:0] SEG_FRONT = 2'd0;
    localparam logic [1:0] SEG_RIGHT = 2'd1;
    localparam logic [1:0] SEG_BACK  = 2'd2;
    localparam logic [1:0] SEG_LEFT  = 2'd3;

    // Derived resolution values
    logic [RW-1:0]   r_cl;
    logic [RW-1:0]   e_next, e_reg;
    logic [RW-1:0]   rm2_next, rm2_reg;
    logic [RW+1:0]   seg_next, seg_reg;
    logic [CW-1:0]   side_next, side_reg;
    logic [CW-1:0]   cap_next, cap_reg;
    logic [CW-1:0]   tot_next, tot_reg;

    // Index capture and divider pipeline
    logic [csvg_pkg::IDX_W-1:0] idx_reg;
    logic [VW-1:0]   ra_reg [0:DIV_ST];
    logic [VW-1:0]   rb_reg [0:DIV_ST];
    logic [QW-1:0]   qa_reg [0:DIV_ST];
    logic [QW-1:0]   qb_reg [0:DIV_ST];
    logic            sd_reg [0:DIV_ST];
    logic            tp_reg [0:DIV_ST];
    logic            iv_reg [0:DIV_ST];
    logic [VW-1:0]   ra_next [0:DIV_ST-1];
    logic [VW-1:0]   rb_next [0:DIV_ST-1];
    logic [QW-1:0]   qa_next [0:DIV_ST-1];
    logic [QW-1:0]   qb_next [0:DIV_ST-1];
    logic            iv0, side0, top0;
    logic [VW-1:0]   j0, jj0;

    // Grid and square stages
    logic signed [DW-1:0] d_next [3];
    logic signed [DW-1:0] d_reg  [3];
    logic                 iv_d_reg;
    logic [2*RW-1:0]      sq_next [3];
    logic [2*RW-1:0]      sq_reg  [3];
    logic [2:0]           neg_next, neg_q_reg, neg_o_reg;
    logic [31:0]          rr_reg;
    logic                 iv_q_reg, iv_o_reg;
    logic [SW-1:0]        s_reg;
    logic [HW-1:0]        rhs_reg [3];

    // Clamp resolution and form face counts
    always_comb
    begin
        if (int'(cfg_resolution) < 2)
            r_cl = RW'(2);
        else if (int'(cfg_resolution) > MAX_RES)
            r_cl = RW'(MAX_RES);
        else
            r_cl = RW'(cfg_resolution);
        e_next    = r_cl - RW'(1);
        rm2_next  = r_cl - RW'(2);
        seg_next  = {e_next, 2'b00};
        side_next = CW'(seg_next) * CW'(r_cl);
        cap_next  = CW'(rm2_next) * CW'(rm2_next);
        tot_next  = side_next + (cap_next << 1);
    end

    always_ff @(posedge clk)
    begin
        e_reg    <= e_next;
        rm2_reg  <= rm2_next;
        seg_reg  <= seg_next;
        side_reg <= side_next;
        cap_reg  <= cap_next;
        tot_reg  <= tot_next;
    end

    // Stage 0: capture index
    always_ff @(posedge clk)
    begin
        if (en[0])
            idx_reg <= vertex_index;
    end

    // Range checks and cap-relative index
    always_comb
    begin
        iv0   = VW'(idx_reg) < VW'(tot_reg);
        side0 = VW'(idx_reg) < VW'(side_reg);
        j0    = VW'(idx_reg) - VW'(side_reg);
        top0  = j0 < VW'(cap_reg);
        jj0   = top0 ? j0 : (j0 - VW'(cap_reg));
    end

    // Divider steps: index by side row length, cap index by inner width
    always_comb
    begin
        logic [VW-1:0] ra_t, rb_t, da, db;
        logic [QW-1:0] qa_t, qb_t;
        int            bp;
        for (int st = 0; st < DIV_ST; st++)
        begin
            ra_t = ra_reg[st];
            rb_t = rb_reg[st];
            qa_t = qa_reg[st];
            qb_t = qb_reg[st];
            for (int h = 0; h < 2; h++)
            begin
                bp = QW - 1 - 2 * st - h;
                if (bp >= 0)
                begin
                    da = VW'(seg_reg) << bp;
                    db = VW'(rm2_reg) << bp;
                    if (ra_t >= da)
                    begin
                        ra_t = ra_t - da;
                        qa_t = qa_t | (QW'(1) << bp);
                    end
                    if (rb_t >= db)
                    begin
                        rb_t = rb_t - db;
                        qb_t = qb_t | (QW'(1) << bp);
                    end
                end
            end
            ra_next[st] = ra_t;
            rb_next[st] = rb_t;
            qa_next[st] = qa_t;
            qb_next[st] = qb_t;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ra_reg[0] <= VW'(idx_reg);
            rb_reg[0] <= jj0;
            qa_reg[0] <= '0;
            qb_reg[0] <= '0;
            sd_reg[0] <= side0;
            tp_reg[0] <= top0;
            iv_reg[0] <= iv0;
        end
        for (int st = 0; st < DIV_ST; st++)
        begin
            if (en[st+2])
            begin
                ra_reg[st+1] <= ra_next[st];
                rb_reg[st+1] <= rb_next[st];
                qa_reg[st+1] <= qa_next[st];
                qb_reg[st+1] <= qb_next[st];
                sd_reg[st+1] <= sd_reg[st];
                tp_reg[st+1] <= tp_reg[st];
                iv_reg[st+1] <= iv_reg[st];
            end
        end
    end

    // Segment split, grid point and centered doubled offsets
    always_comb
    begin
        logic [RW+1:0] rem;
        logic [1:0]    seg;
        logic [RW-1:0] t, gx, gy, gz;
        rem = ra_reg[DIV_ST][RW+1:0];
        seg = 2'b00;
        if (rem >= {e_reg, 1'b0})
        begin
            seg[1] = 1'b1;
            rem    = rem - {1'b0, e_reg, 1'b0};
        end
        if (rem >= (RW+2)'(e_reg))
        begin
            seg[0] = 1'b1;
            rem    = rem - (RW+2)'(e_reg);
        end
        t = rem[RW-1:0];
        if (sd_reg[DIV_ST])
        begin
            gy = RW'(qa_reg[DIV_ST]);
            case (seg)
                SEG_FRONT: begin gx = t;             gz = '0;            end
                SEG_RIGHT: begin gx = e_reg;         gz = t;             end
                SEG_BACK:  begin gx = e_reg - t;     gz = e_reg;         end
                SEG_LEFT:  begin gx = '0;            gz = e_reg - t;     end
                default:   begin gx = '0;            gz = '0;            end
            endcase
        end
        else
        begin
            gx = RW'(rb_reg[DIV_ST]) + RW'(1);
            gz = RW'(qb_reg[DIV_ST]) + RW'(1);
            gy = tp_reg[DIV_ST] ? e_reg : '0;
        end
        d_next[0] = $signed(DW'({gx, 1'b0}) - DW'(e_reg));
        d_next[1] = $signed(DW'({gy, 1'b0}) - DW'(e_reg));
        d_next[2] = $signed(DW'({gz, 1'b0}) - DW'(e_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV_ST+2])
        begin
            d_reg    <= d_next;
            iv_d_reg <= iv_reg[DIV_ST];
        end
    end

    // Squares of the offsets and of the radius
    always_comb
    begin
        logic signed [DW-1:0] ad;
        for (int a = 0; a < 3; a++)
        begin
            neg_next[a] = d_reg[a][DW-1];
            ad          = neg_next[a] ? -d_reg[a] : d_reg[a];
            sq_next[a]  = (2*RW)'(RW'(ad)) * (2*RW)'(RW'(ad));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV_ST+3])
        begin
            sq_reg    <= sq_next;
            neg_q_reg <= neg_next;
            rr_reg    <= 32'(cfg_radius) * 32'(cfg_radius);
            iv_q_reg  <= iv_d_reg;
        end
    end

    // |D|^2 and per-axis 4*R^2*d^2
    always_ff @(posedge clk)
    begin
        if (en[DEC_ST-1])
        begin
            s_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            for (int a = 0; a < 3; a++)
                rhs_reg[a] <= (HW'(rr_reg) * HW'(sq_reg[a])) << 2;
            neg_o_reg <= neg_q_reg;
            iv_o_reg  <= iv_q_reg;
        end
    end

    assign s_out   = s_reg;
    assign rhs_out = rhs_reg;
    assign neg_out = neg_o_reg;
    assign iv_out  = iv_o_reg;

endmodule

FILE: hdl/csvg_scale.sv
// One axis of the scaler: finds the largest q with (2q-1)^2 * s <= 4*R^2*d^2.
// Depends on csvg_pkg. One result bit per stage, MSB first, shift-and-add only.
module csvg_scale #(
    parameter int MAX_RES = csvg_pkg::MAX_RES_DEF
) (
    input  logic                                    clk,
    input  logic [csvg_pkg::NSTEP-1:0]              en,
    input  logic [2*csvg_pkg::res_w(MAX_RES)+1:0]   s_in,
    input  logic [2*csvg_pkg::res_w(MAX_RES)+33:0]  rhs_in,
    input  logic                                    neg_in,
    output logic [csvg_pkg::RAD_W-1:0]              q_out,
    output logic                                    neg_out
);

    localparam int RW = csvg_pkg::res_w(MAX_RES);
    localparam int SW = 2 * RW + 2;
    localparam int HW = 2 * RW + 34;
    localparam int AW = 2 * RW + 38;
    localparam int NS = csvg_pkg::NSTEP;
    localparam int QW = csvg_pkg::RAD_W;

    // A = t^2*s and B = t*s for t = 2q-1
    logic signed [AW-1:0] a_reg [0:NS-1];
    logic signed [AW-1:0] b_reg [0:NS-1];
    logic [QW-1:0]        q_reg [0:NS-1];
    logic [SW-1:0]        s_reg [0:NS-1];
    logic [HW-1:0]        h_reg [0:NS-1];
    logic                 n_reg [0:NS-1];
    logic signed [AW-1:0] a_next [0:NS-1];
    logic signed [AW-1:0] b_next [0:NS-1];
    logic [QW-1:0]        q_next [0:NS-1];

    // Trial of one more bit: t grows by 2^(bp+1)
    always_comb
    begin
        logic signed [AW-1:0] a_t, b_t, s_t, a_c, b_c;
        logic [QW-1:0]        q_t;
        logic [HW-1:0]        h_t;
        int                   bp;
        for (int k = 0; k < NS; k++)
        begin
            bp = NS - 1 - k;
            if (k == 0)
            begin
                s_t = $signed(AW'(s_in));
                a_t = s_t;
                b_t = -s_t;
                q_t = '0;
                h_t = rhs_in;
            end
            else
            begin
                s_t = $signed(AW'(s_reg[k-1]));
                a_t = a_reg[k-1];
                b_t = b_reg[k-1];
                q_t = q_reg[k-1];
                h_t = h_reg[k-1];
            end
            a_c = a_t + (b_t <<< (bp + 2)) + (s_t <<< (2 * bp + 2));
            b_c = b_t + (s_t <<< (bp + 1));
            if (a_c <= $signed(AW'(h_t)))
            begin
                a_next[k] = a_c;
                b_next[k] = b_c;
                q_next[k] = q_t | (QW'(1) << bp);
            end
            else
            begin
                a_next[k] = a_t;
                b_next[k] = b_t;
                q_next[k] = q_t;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                a_reg[k] <= a_next[k];
                b_reg[k] <= b_next[k];
                q_reg[k] <= q_next[k];
                s_reg[k] <= (k == 0) ? s_in : s_reg[k-1];
                h_reg[k] <= (k == 0) ? rhs_in : h_reg[k-1];
                n_reg[k] <= (k == 0) ? neg_in : n_reg[k-1];
            end
        end
    end

    assign q_out   = q_reg[NS-1];
    assign neg_out = n_reg[NS-1];

endmodule
